// ===== rtl/tfe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Telemetry frame encoder package
// Shared byte codes, frame type and queue sizing.
// ----------------------------------------------------------------------------
package tfe_pkg;

  localparam logic [7:0] FLAG_BYTE    = 8'h7E;
  localparam logic [7:0] ESC_MARK     = 8'h7D;
  localparam logic [7:0] ESC_FLAG     = 8'h5E;
  localparam logic [7:0] ESC_ESC      = 8'h5D;
  localparam logic [7:0] HEADER_RESET = 8'h10;

  localparam int FRAME_BYTES = 8;
  localparam int SUM_W       = 11;
  localparam int QUEUE_DEPTH = 2;

  typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

endpackage

// ===== rtl/tfe_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Telemetry frame encoder front end
// Accepts a reading, lays out the frame bytes and forms the checksum.
// ----------------------------------------------------------------------------
module tfe_front
  import tfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  frame_header,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] sensor_id,
  input  logic [31:0] sensor_value,
  output logic        push_valid,
  input  logic        push_ready,
  output frame_t      push_frame
);

  logic                  valid_r, valid_nxt;
  logic [6:0][7:0]       bytes_r;
  logic [SUM_W-1:0]      sum_r;
  logic [6:0][7:0]       bytes_nxt;
  logic [SUM_W-1:0]      sum_nxt;
  logic [SUM_W-1:0]      total;

  assign in_ready = !valid_r || push_ready;

  always_comb begin
    bytes_nxt = {sensor_value, sensor_id, frame_header};
    sum_nxt   = '0;
    for (int i = 0; i < 7; i++) begin
      sum_nxt = sum_nxt + SUM_W'(bytes_nxt[i]);
    end
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (push_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      bytes_r <= bytes_nxt;
      sum_r   <= sum_nxt;
    end
  end

  // fold the carry back in once; 0xFF minus the total is its complement
  assign total      = sum_r + {8'h00, sum_r[SUM_W-1:8]};
  assign push_valid = valid_r;
  assign push_frame = {~total[7:0], bytes_r};

endmodule

// ===== rtl/tfe_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Telemetry frame encoder frame queue
// Short register queue of whole frames between front and back end.
// ----------------------------------------------------------------------------
module tfe_queue
  import tfe_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push_valid,
  output logic   push_ready,
  input  frame_t push_frame,
  output logic   pop_valid,
  input  logic   pop_ready,
  output frame_t pop_frame
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  frame_t           mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_frame  = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_frame;
    end
  end

endmodule

// ===== rtl/tfe_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Telemetry frame encoder back end
// Walks the head frame byte by byte, escapes flag and escape bytes.
// ----------------------------------------------------------------------------
module tfe_back
  import tfe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       pop_valid,
  output logic       pop_ready,
  input  frame_t     pop_frame,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] line_byte,
  output logic       frame_end
);

  localparam int IDX_W = $clog2(FRAME_BYTES);

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             esc_r, esc_nxt;
  logic             valid_r, valid_nxt;
  logic [7:0]       byte_r, byte_nxt;
  logic             last_r, last_nxt;
  logic             step;
  logic [7:0]       cur;
  logic             is_last;

  assign step    = pop_valid && (!valid_r || out_ready);
  assign cur     = pop_frame[idx_r];
  assign is_last = (idx_r == IDX_W'(FRAME_BYTES - 1));

  always_comb begin
    idx_nxt   = idx_r;
    esc_nxt   = esc_r;
    byte_nxt  = byte_r;
    last_nxt  = last_r;
    pop_ready = 1'b0;
    valid_nxt = valid_r && !out_ready;
    if (step) begin
      valid_nxt = 1'b1;
      if (esc_r) begin
        // second half of an escape pair
        byte_nxt  = (cur == FLAG_BYTE) ? ESC_FLAG : ESC_ESC;
        last_nxt  = is_last;
        esc_nxt   = 1'b0;
        idx_nxt   = idx_r + 1'b1;
        pop_ready = is_last;
      end else if (cur == FLAG_BYTE || cur == ESC_MARK) begin
        byte_nxt = ESC_MARK;
        last_nxt = 1'b0;
        esc_nxt  = 1'b1;
      end else begin
        byte_nxt  = cur;
        last_nxt  = is_last;
        idx_nxt   = idx_r + 1'b1;
        pop_ready = is_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      esc_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      esc_r   <= esc_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= last_nxt;
  end

  assign out_valid = valid_r;
  assign line_byte = byte_r;
  assign frame_end = last_r;

endmodule

// ===== rtl/telemetry_frame_encoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Telemetry frame encoder
// Turns one sensor reading into a byte-stuffed frame with a sum checksum.
//
//   channel  ports                           payload
//   input    in_tvalid/in_tready             tdata[15:0] sensor_id,
//                                            tdata[47:16] sensor_value
//   output   out_tvalid/out_tready           tdata[7:0] line_byte,
//                                            tlast frame_end
//   config   cfg_valid/cfg_ready             cfg_data[7:0] frame_header
//
// One reading yields 8 to 16 line bytes, one per cycle while out_tready is high;
// the back end's byte walk sets the sustained rate of readings.
// The first line byte of a reading passes the front register, the frame queue
// and the back end's output register before it is offered.
// The frame queue lets the front end take new readings while the output stalls.
// Reset is synchronous, active low; the header returns to 0x10.
// ----------------------------------------------------------------------------
module telemetry_frame_encoder_top
  import tfe_pkg::*;
#(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [15:0] sensor_id, [47:16] sensor_value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] line_byte
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  logic [7:0] header_r, header_nxt;
  logic       push_valid, push_ready;
  frame_t     push_frame;
  logic       pop_valid, pop_ready;
  frame_t     pop_frame;

  assign cfg_ready  = 1'b1;
  assign header_nxt = (cfg_valid && cfg_ready) ? cfg_data : header_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= HEADER_RESET;
    end else begin
      header_r <= header_nxt;
    end
  end

  tfe_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .frame_header (header_r),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .sensor_id    (in_tdata[15:0]),
    .sensor_value (in_tdata[47:16]),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_frame   (push_frame)
  );

  tfe_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_frame (push_frame),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_frame  (pop_frame)
  );

  tfe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_frame (pop_frame),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .line_byte (out_tdata),
    .frame_end (out_tlast)
  );

endmodule
